@@ rtl/core/otsu_pkg.sv @@
package otsu_pkg;

	// Frame-level sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_FILL,
		ST_DRAIN,
		ST_SUM,
		ST_SUM_TAIL,
		ST_EV_RD,
		ST_EV_GO,
		ST_EV_WAIT,
		ST_PUT
	} seq_state_t;

	// Per-threshold evaluation states
	typedef enum logic [2:0] {
		EV_IDLE,
		EV_XY,
		EV_DIFF,
		EV_NUM,
		EV_LHS,
		EV_RHS
	} ev_state_t;

	// Control from the sequencer to the evaluator
	typedef struct packed {
		logic init;
		logic start;
	} ev_ctl_t;

	localparam logic [7:0] NO_THRESHOLD = 8'd255;

endpackage

@@ rtl/core/otsu_ram.sv @@
module otsu_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/otsu_mul.sv @@
module otsu_mul #(
	parameter int WA = 100,
	parameter int WB = 50
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic             done,
	output logic [WA+WB-1:0] p
);

	localparam int PW = WA + WB;
	localparam int CW = $clog2(WB + 1);

	logic [PW-1:0] acc_q;
	logic [PW-1:0] a_sh_q;
	logic [WB-1:0] b_sh_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	// Shift-add, one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(WB - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			a_sh_q <= PW'(a);
			b_sh_q <= b;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (b_sh_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= a_sh_q << 1;
			b_sh_q <= b_sh_q >> 1;
			cnt_q  <= cnt_q + CW'(1);
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

@@ rtl/core/otsu_eval.sv @@
module otsu_eval import otsu_pkg::*; #(
	parameter int COUNT_BITS = 21,
	parameter int LW         = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ev_ctl_t                  ctl,
	input  logic [LW-1:0]            level,
	input  logic [COUNT_BITS-1:0]    cnt,
	input  logic [COUNT_BITS-1:0]    total,
	input  logic [COUNT_BITS+LW-1:0] sum,
	output logic                     done,
	output logic [7:0]               best
);

	localparam int CB   = COUNT_BITS;
	localparam int SUMW = CB + LW;
	localparam int DW   = 2 * CB + LW;
	localparam int DENW = 2 * CB;
	localparam int NUMW = 2 * DW;
	localparam int PW   = NUMW + DW;

	ev_state_t state_q, state_d;

	logic [CB-1:0]   w0_q;
	logic [SUMW-1:0] s0_q;
	logic [LW-1:0]   t_q;
	logic [DW-1:0]   x_q, y_q;
	logic [DENW-1:0] den_q;
	logic [NUMW-1:0] num_q;
	logic [PW-1:0]   lhs_q;
	logic [NUMW-1:0] best_num_q;
	logic [DENW-1:0] best_den_q;
	logic [7:0]      best_t_q;

	logic [CB-1:0]   w1;
	logic [SUMW-1:0] s1;
	logic            skip;
	logic [DW-1:0]   d;
	logic            mul_start;
	logic [NUMW-1:0] mul_a;
	logic [DW-1:0]   mul_b;
	logic            mul_done;
	logic [PW-1:0]   mul_p;
	logic            better;

	// Upper class weight and level sum
	assign w1     = total - w0_q;
	assign s1     = sum - s0_q;
	assign skip   = (w0_q == '0) || (w1 == '0);
	assign d      = (x_q >= y_q) ? (x_q - y_q) : (y_q - x_q);
	assign better = lhs_q > mul_p;

	otsu_mul #(.WA(NUMW), .WB(DW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EV_IDLE: if (ctl.start) state_d = EV_XY;
			EV_XY:   state_d = skip ? EV_IDLE : EV_DIFF;
			EV_DIFF: state_d = EV_NUM;
			EV_NUM:  if (mul_done) state_d = EV_LHS;
			EV_LHS:  if (mul_done) state_d = EV_RHS;
			EV_RHS:  if (mul_done) state_d = EV_IDLE;
			default: state_d = EV_IDLE;
		endcase
	end

	// Multiplier operand select and completion
	always_comb begin
		mul_start = 1'b0;
		mul_a     = NUMW'(d);
		mul_b     = d;
		done      = 1'b0;
		unique case (state_q)
			EV_IDLE: ;
			EV_XY:   done = skip;
			EV_DIFF: mul_start = 1'b1;
			EV_NUM: begin
				mul_start = mul_done;
				mul_a     = mul_p[NUMW-1:0];
				mul_b     = DW'(best_den_q);
			end
			EV_LHS: begin
				mul_start = mul_done;
				mul_a     = best_num_q;
				mul_b     = DW'(den_q);
			end
			EV_RHS:  done = mul_done;
			default: ;
		endcase
	end

	// Running class sums, products and best candidate
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			w0_q       <= '0;
			s0_q       <= '0;
			best_num_q <= '0;
			best_den_q <= DENW'(1);
			best_t_q   <= NO_THRESHOLD;
		end else begin
			if (state_q == EV_IDLE && ctl.start) begin
				w0_q <= w0_q + cnt;
				s0_q <= s0_q + SUMW'(level) * SUMW'(cnt);
				t_q  <= level;
			end
			if (state_q == EV_XY) begin
				x_q   <= DW'(s1) * DW'(w0_q);
				y_q   <= DW'(s0_q) * DW'(w1);
				den_q <= DENW'(w0_q) * DENW'(w1);
			end
			if (state_q == EV_NUM && mul_done) begin
				num_q <= mul_p[NUMW-1:0];
			end
			if (state_q == EV_LHS && mul_done) begin
				lhs_q <= mul_p;
			end
			if (state_q == EV_RHS && mul_done && better) begin
				best_num_q <= num_q;
				best_den_q <= den_q;
				best_t_q   <= 8'(t_q);
			end
		end
	end

	assign best = best_t_q;

endmodule

@@ rtl/core/otsu_threshold_finder.sv @@
// Otsu threshold finder: pixels stream in one per clock (in_stall low) into a
// histogram held in a block RAM, with read-modify-write forwarding so repeated
// gray levels back to back count correctly. After the pixel marked last,
// input stalls while the frame is evaluated: one pass builds the level sum,
// then each level up to the largest seen is evaluated by the shared
// bit-serial multiplier that forms the squared difference and the two cross
// products, unless one class is empty at that level. Bins are zeroed as
// they are evaluated. The threshold waits in an output register, so the
// next frame can start while it is still stalled. After reset the
// histogram RAM is cleared bin by bin before the first pixel is taken.
// Pixels at or above LEVELS count in the top bin; once the pixel count
// saturates, further pixels are ignored but last still ends the frame.
module otsu_threshold_finder import otsu_pkg::*; #(
	parameter int COUNT_BITS = 21,
	parameter int LEVELS     = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pixel,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] threshold
);

	localparam int CB   = COUNT_BITS;
	localparam int LW   = $clog2(LEVELS);
	localparam int SUMW = CB + LW;
	localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);

	seq_state_t state_q, state_d;

	logic [LW-1:0]   t_q;
	logic [LW-1:0]   peak_q;
	logic [CB-1:0]   total_q;
	logic [SUMW-1:0] sum_q;
	logic            v_s1;
	logic [LW-1:0]   addr_s1;
	logic            rd_v_s1;
	logic [LW-1:0]   rd_t_s1;
	logic            wv_q;
	logic [LW-1:0]   waddr_q;
	logic [CB-1:0]   wdata_q;
	logic            out_valid_q;
	logic [7:0]      threshold_q;

	logic            accept;
	logic [LW-1:0]   p;
	logic            counted;
	logic [CB-1:0]   base;
	logic [CB-1:0]   inc;
	logic            we;
	logic [LW-1:0]   waddr;
	logic [CB-1:0]   wdata;
	logic [LW-1:0]   raddr;
	logic [CB-1:0]   rdata;
	logic            out_free;
	ev_ctl_t         ev_ctl;
	logic            ev_done;
	logic [7:0]      ev_best;

	assign in_stall = (state_q != ST_FILL);
	assign accept   = in_valid && !in_stall;
	assign p        = ({1'b0, pixel} >= 9'(LEVELS)) ? TOP : pixel[LW-1:0];
	assign counted  = (total_q != '1);
	assign out_free = !out_valid_q || !out_stall;

	// Forward the previous cycle's write on a same-bin hit
	assign base = (wv_q && waddr_q == addr_s1) ? wdata_q : rdata;
	assign inc  = base + CB'(1);

	// RAM port select
	always_comb begin
		we    = 1'b0;
		waddr = t_q;
		wdata = '0;
		raddr = (state_q == ST_FILL) ? p : t_q;
		if (state_q == ST_CLEAR || state_q == ST_EV_GO) begin
			we = 1'b1;
		end else if (v_s1) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = inc;
		end
	end

	otsu_ram #(.WIDTH(CB), .DEPTH(LEVELS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Evaluator control
	always_comb begin
		ev_ctl.init  = (state_q == ST_DRAIN);
		ev_ctl.start = (state_q == ST_EV_GO);
	end

	otsu_eval #(.COUNT_BITS(CB), .LW(LW)) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ev_ctl),
		.level  (t_q),
		.cnt    (rdata),
		.total  (total_q),
		.sum    (sum_q),
		.done   (ev_done),
		.best   (ev_best)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:    if (t_q == TOP) state_d = ST_FILL;
			ST_FILL:     if (accept && last) state_d = ST_DRAIN;
			ST_DRAIN:    state_d = ST_SUM;
			ST_SUM:      if (t_q == peak_q) state_d = ST_SUM_TAIL;
			ST_SUM_TAIL: state_d = ST_EV_RD;
			ST_EV_RD:    state_d = ST_EV_GO;
			ST_EV_GO:    state_d = ST_EV_WAIT;
			ST_EV_WAIT: begin
				if (ev_done) state_d = (t_q == peak_q) ? ST_PUT : ST_EV_RD;
			end
			ST_PUT:      if (out_free) state_d = ST_FILL;
			default:     state_d = ST_CLEAR;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			t_q         <= '0;
			peak_q      <= '0;
			total_q     <= '0;
			v_s1        <= 1'b0;
			rd_v_s1     <= 1'b0;
			wv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= accept && counted;
			rd_v_s1 <= (state_q == ST_SUM);
			wv_q    <= v_s1;

			// advance the level counter
			case (state_q) inside
				ST_CLEAR, ST_SUM: t_q <= (state_d == state_q) ? t_q + LW'(1) : '0;
				ST_EV_WAIT: if (ev_done && t_q != peak_q) t_q <= t_q + LW'(1);
				ST_PUT:     t_q <= '0;
				default: ;
			endcase

			// count the accepted pixel
			if (accept && counted) begin
				total_q <= total_q + CB'(1);
				if (p > peak_q) peak_q <= p;
			end

			// hand off the result, drop frame totals
			if (state_q == ST_PUT && out_free) begin
				out_valid_q <= 1'b1;
				total_q     <= '0;
				peak_q      <= '0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= p;
		rd_t_s1 <= t_q;
		waddr_q <= addr_s1;
		wdata_q <= inc;
		if (state_q == ST_DRAIN) begin
			sum_q <= '0;
		end else if (rd_v_s1) begin
			sum_q <= sum_q + SUMW'(rd_t_s1) * SUMW'(rdata);
		end
		if (state_q == ST_PUT && out_free) begin
			threshold_q <= ev_best;
		end
	end

	assign out_valid = out_valid_q;
	assign threshold = threshold_q;

endmodule
